// ===== sv/lmsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lmsp_pkg: shared types and constants of the LED matrix scan/PWM loader
// Sequencer states, shared unit request/response types, fixed widths.
// ----------------------------------------------------------------------------
package lmsp_pkg;

	localparam int LEVEL_W    = 8;
	localparam int TIME_W     = 16;
	localparam int UNIT_W     = 16;
	localparam int DRIVE_W    = 9;
	localparam int ENTRIES    = 9;
	localparam int IDX_W      = 4;
	localparam int LOAD_GROUP = 3;
	localparam int CFG_IDX_W  = 2;

	localparam logic [IDX_W-1:0]   LOAD_BYTES = 4'd9;
	localparam logic [IDX_W-1:0]   LAST_BYTE  = 4'd8;
	localparam logic [LEVEL_W-1:0] LEVEL_STEP = 8'd3;

	localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 8'd50;
	localparam logic [TIME_W-1:0]  ON_TIME_RST   = 16'd100;
	localparam logic [TIME_W-1:0]  OFF_TIME_RST  = 16'd10;
	localparam logic [LEVEL_W-1:0] THRESH_RST    = 8'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_TIME  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_CMP,
		S_THR_ADD,
		S_THR_CMP,
		S_THR_SUB,
		S_LOAD,
		S_FIN
	} seq_state_t;

	typedef enum logic {
		OP_ADD,
		OP_SUB
	} unit_op_t;

	typedef struct packed {
		unit_op_t          op;
		logic [UNIT_W-1:0] a;
		logic [UNIT_W-1:0] b;
	} unit_req_t;

	typedef struct packed {
		logic [UNIT_W-1:0] res;
		logic              ge;
	} unit_rsp_t;

endpackage

// ===== sv/lmsp_alu.sv =====
// ----------------------------------------------------------------------------
// lmsp_alu: shared add/subtract/compare unit
// One adder used by the sequencer for countdown, threshold and level compare.
// ----------------------------------------------------------------------------
module lmsp_alu (
	input  lmsp_pkg::unit_req_t req,
	output lmsp_pkg::unit_rsp_t rsp
);

	logic [lmsp_pkg::UNIT_W:0] diff;

	assign diff = {1'b0, req.a} - {1'b0, req.b};

	always_comb begin
		// unsigned a >= b from the borrow of a - b
		rsp.ge = ~diff[lmsp_pkg::UNIT_W];
		case (req.op)
			lmsp_pkg::OP_ADD: rsp.res = req.a + req.b;
			lmsp_pkg::OP_SUB: rsp.res = diff[lmsp_pkg::UNIT_W-1:0];
			default:          rsp.res = diff[lmsp_pkg::UNIT_W-1:0];
		endcase
	end

endmodule

// ===== sv/lmsp_frame_store.sv =====
// ----------------------------------------------------------------------------
// lmsp_frame_store: double-buffered level store
// Load buffer filled byte by byte, committed to the display copy at once.
// ----------------------------------------------------------------------------
module lmsp_frame_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic                          wr_keep,
	input  logic [lmsp_pkg::IDX_W-1:0]    wr_idx,
	input  logic [lmsp_pkg::LEVEL_W-1:0]  wr_data,
	input  logic [lmsp_pkg::IDX_W-1:0]    rd_idx,
	output logic [lmsp_pkg::LEVEL_W-1:0]  rd_level
);

	logic [lmsp_pkg::LEVEL_W-1:0] buf_q  [lmsp_pkg::ENTRIES];
	logic [lmsp_pkg::LEVEL_W-1:0] disp_q [lmsp_pkg::ENTRIES];
	logic [lmsp_pkg::LEVEL_W-1:0] buf_nx [lmsp_pkg::ENTRIES];

	// first byte clears the buffer, then the byte lands if its column exists
	always_comb begin
		for (int i = 0; i < lmsp_pkg::ENTRIES; i++) begin
			if (wr_idx == '0)
				buf_nx[i] = '0;
			else
				buf_nx[i] = buf_q[i];
			if (wr_keep && (wr_idx == lmsp_pkg::IDX_W'(i)))
				buf_nx[i] = wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lmsp_pkg::ENTRIES; i++) begin
				buf_q[i]  <= '0;
				disp_q[i] <= '0;
			end
		end else if (wr_en) begin
			for (int i = 0; i < lmsp_pkg::ENTRIES; i++) begin
				buf_q[i] <= buf_nx[i];
				if (wr_idx == lmsp_pkg::LAST_BYTE)
					disp_q[i] <= buf_nx[i];
			end
		end
	end

	always_comb begin
		if (rd_idx < lmsp_pkg::IDX_W'(lmsp_pkg::ENTRIES))
			rd_level = disp_q[rd_idx];
		else
			rd_level = '0;
	end

endmodule

// ===== sv/led_matrix_scan_pwm_loader_core.sv =====
// ----------------------------------------------------------------------------
// led_matrix_scan_pwm_loader_core: multiplexed RGB LED matrix PWM driver
// Timer ticks run the scan/PWM phase machine, level bytes fill a frame buffer.
// ----------------------------------------------------------------------------
// Per item the sequencer steps through S_LOAD for a byte, S_DEC for a running
// tick, S_THR_ADD and S_THR_CMP for a blanking tick plus S_THR_SUB when the
// threshold wraps, or S_CMP once per channel for an on-phase tick (one channel
// compare per cycle through the shared adder), then S_FIN. in_ready is low
// while an item is in progress or its result cannot be stored.
// Reset: asynchronous active low, stores clear at once, no clearing pass.
// ----------------------------------------------------------------------------
module led_matrix_scan_pwm_loader_core #(
	parameter int COLUMNS  = 9,
	parameter int CHANNELS = 9
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [lmsp_pkg::LEVEL_W-1:0]      data_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lmsp_pkg::DRIVE_W-1:0]      channel_drive,
	output logic [lmsp_pkg::DRIVE_W-1:0]      column_drive,
	output logic                              frame_loaded,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lmsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lmsp_pkg::TIME_W-1:0]       cfg_data
);

	localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int CH_W    = $clog2(CHANNELS);
	localparam int EXT_W   = CHANNELS + lmsp_pkg::DRIVE_W;
	localparam int STORE_N = lmsp_pkg::LOAD_GROUP * COLUMNS;

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
	localparam logic [CH_W-1:0]  LAST_CH  = CH_W'(CHANNELS - 1);

	// configuration
	logic [lmsp_pkg::LEVEL_W-1:0] max_level_q;
	logic [lmsp_pkg::TIME_W-1:0]  on_time_q;
	logic [lmsp_pkg::TIME_W-1:0]  off_time_q;

	// scan state
	lmsp_pkg::seq_state_t         state_q, state_nx;
	logic [COL_W-1:0]             column_q;
	logic [lmsp_pkg::LEVEL_W-1:0] thresh_q;
	logic [lmsp_pkg::LEVEL_W-1:0] thresh_tmp_q;
	logic                         phase_on_q;
	logic [lmsp_pkg::TIME_W-1:0]  countdown_q;
	logic [lmsp_pkg::IDX_W-1:0]   byte_cnt_q;
	logic [lmsp_pkg::DRIVE_W-1:0] ch_drive_q;
	logic [lmsp_pkg::DRIVE_W-1:0] col_drive_q;

	// item in progress
	logic [lmsp_pkg::LEVEL_W-1:0] data_q;
	logic                         loaded_q;
	logic [CH_W-1:0]              ch_idx_q;
	logic [CHANNELS-1:0]          ch_bits_q;

	// output register
	logic                         out_valid_q;
	logic [lmsp_pkg::DRIVE_W-1:0] out_ch_q;
	logic [lmsp_pkg::DRIVE_W-1:0] out_col_q;
	logic                         out_loaded_q;

	lmsp_pkg::unit_req_t          unit_req;
	lmsp_pkg::unit_rsp_t          unit_rsp;

	logic                         in_fire;
	logic                         out_free;
	logic [5:0]                   col_x;
	logic [5:0]                   ch_x;
	logic                         rd_hit;
	logic [lmsp_pkg::IDX_W-1:0]   rd_idx;
	logic [lmsp_pkg::LEVEL_W-1:0] rd_level;
	logic [lmsp_pkg::LEVEL_W-1:0] level_cur;
	logic [CHANNELS-1:0]          ch_final;
	logic [EXT_W-1:0]             ch_ext;
	logic [15:0]                  col_onehot;
	logic                         load_en;
	logic                         load_keep;

	assign in_ready  = (state_q == lmsp_pkg::S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign channel_drive = out_ch_q;
	assign column_drive  = out_col_q;
	assign frame_loaded  = out_loaded_q;

	// register writes; index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_level_q <= lmsp_pkg::MAX_LEVEL_RST;
			on_time_q   <= lmsp_pkg::ON_TIME_RST;
			off_time_q  <= lmsp_pkg::OFF_TIME_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lmsp_pkg::CFG_MAX_LEVEL: max_level_q <= cfg_data[lmsp_pkg::LEVEL_W-1:0];
				lmsp_pkg::CFG_ON_TIME:   on_time_q   <= cfg_data;
				lmsp_pkg::CFG_OFF_TIME:  off_time_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// display read: only channels 0..2 of columns 0..2 are ever loaded,
	// every other level stays zero
	assign col_x     = 6'(column_q);
	assign ch_x      = 6'(ch_idx_q);
	assign rd_hit    = (ch_x < 6'(lmsp_pkg::LOAD_GROUP)) && (col_x < 6'(lmsp_pkg::LOAD_GROUP));
	assign rd_idx    = lmsp_pkg::IDX_W'(col_x * 6'd3 + ch_x);
	assign level_cur = rd_hit ? rd_level : '0;

	// byte write enables, a level whose column is missing is dropped
	assign load_en   = (state_q == lmsp_pkg::S_LOAD) && (byte_cnt_q < lmsp_pkg::LOAD_BYTES);
	assign load_keep = (6'(byte_cnt_q) < 6'(STORE_N));

	lmsp_frame_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (load_en),
		.wr_keep  (load_keep),
		.wr_idx   (byte_cnt_q),
		.wr_data  (data_q),
		.rd_idx   (rd_idx),
		.rd_level (rd_level)
	);

	lmsp_alu u_alu (
		.req (unit_req),
		.rsp (unit_rsp)
	);

	// channel bits with the last compare folded in, clipped to the drive width
	assign ch_final   = ch_bits_q | (CHANNELS'(unit_rsp.ge) << ch_idx_q);
	assign ch_ext     = EXT_W'(ch_final);
	assign col_onehot = 16'(1) << column_q;

	// sequencer: next state and shared unit request
	always_comb begin
		state_nx     = state_q;
		unit_req.op  = lmsp_pkg::OP_SUB;
		unit_req.a   = lmsp_pkg::UNIT_W'(level_cur);
		unit_req.b   = lmsp_pkg::UNIT_W'(thresh_q);
		case (state_q)
			lmsp_pkg::S_IDLE: begin
				if (in_fire) begin
					if (kind)
						state_nx = lmsp_pkg::S_LOAD;
					else if (countdown_q != '0)
						state_nx = lmsp_pkg::S_DEC;
					else if (phase_on_q)
						state_nx = lmsp_pkg::S_CMP;
					else
						state_nx = lmsp_pkg::S_THR_ADD;
				end
			end
			lmsp_pkg::S_DEC: begin
				unit_req.a = countdown_q;
				unit_req.b = lmsp_pkg::UNIT_W'(1);
				state_nx   = lmsp_pkg::S_FIN;
			end
			lmsp_pkg::S_CMP: begin
				if (ch_idx_q == LAST_CH)
					state_nx = lmsp_pkg::S_FIN;
			end
			lmsp_pkg::S_THR_ADD: begin
				unit_req.op = lmsp_pkg::OP_ADD;
				unit_req.a  = lmsp_pkg::UNIT_W'(thresh_q);
				unit_req.b  = lmsp_pkg::UNIT_W'(lmsp_pkg::LEVEL_STEP);
				state_nx    = lmsp_pkg::S_THR_CMP;
			end
			lmsp_pkg::S_THR_CMP: begin
				// max >= sum keeps the sum, otherwise wrap once
				unit_req.a = lmsp_pkg::UNIT_W'(max_level_q);
				unit_req.b = lmsp_pkg::UNIT_W'(thresh_tmp_q);
				state_nx   = unit_rsp.ge ? lmsp_pkg::S_FIN : lmsp_pkg::S_THR_SUB;
			end
			lmsp_pkg::S_THR_SUB: begin
				unit_req.a = lmsp_pkg::UNIT_W'(thresh_tmp_q);
				unit_req.b = lmsp_pkg::UNIT_W'(max_level_q);
				state_nx   = lmsp_pkg::S_FIN;
			end
			lmsp_pkg::S_LOAD: begin
				state_nx = lmsp_pkg::S_FIN;
			end
			lmsp_pkg::S_FIN: begin
				if (out_free)
					state_nx = lmsp_pkg::S_IDLE;
			end
			default: begin
				state_nx = lmsp_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lmsp_pkg::S_IDLE;
		else
			state_q <= state_nx;
	end

	// scan and load state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			thresh_q     <= lmsp_pkg::THRESH_RST;
			thresh_tmp_q <= '0;
			phase_on_q   <= 1'b1;
			countdown_q  <= '0;
			byte_cnt_q   <= '0;
			ch_drive_q   <= '0;
			col_drive_q  <= '0;
			loaded_q     <= 1'b0;
			ch_idx_q     <= '0;
			ch_bits_q    <= '0;
		end else begin
			case (state_q)
				lmsp_pkg::S_IDLE: begin
					if (in_fire) begin
						loaded_q  <= 1'b0;
						ch_idx_q  <= '0;
						ch_bits_q <= '0;
						if (!kind && countdown_q == '0 && !phase_on_q) begin
							// blanking phase: clear drive, advance column
							ch_drive_q  <= '0;
							col_drive_q <= '0;
							column_q    <= (column_q == LAST_COL) ? '0 : column_q + 1'b1;
							countdown_q <= off_time_q;
							phase_on_q  <= 1'b1;
						end
					end
				end
				lmsp_pkg::S_DEC: begin
					countdown_q <= unit_rsp.res;
				end
				lmsp_pkg::S_CMP: begin
					ch_bits_q <= ch_final;
					ch_idx_q  <= ch_idx_q + 1'b1;
					if (ch_idx_q == LAST_CH) begin
						ch_drive_q  <= ch_ext[lmsp_pkg::DRIVE_W-1:0];
						col_drive_q <= col_onehot[lmsp_pkg::DRIVE_W-1:0];
						countdown_q <= on_time_q;
						phase_on_q  <= 1'b0;
					end
				end
				lmsp_pkg::S_THR_ADD: begin
					thresh_tmp_q <= unit_rsp.res[lmsp_pkg::LEVEL_W-1:0];
				end
				lmsp_pkg::S_THR_CMP: begin
					if (unit_rsp.ge)
						thresh_q <= thresh_tmp_q;
				end
				lmsp_pkg::S_THR_SUB: begin
					thresh_q <= unit_rsp.res[lmsp_pkg::LEVEL_W-1:0];
				end
				lmsp_pkg::S_LOAD: begin
					// count out of range would only rewind, with no write
					if (byte_cnt_q >= lmsp_pkg::LOAD_BYTES || byte_cnt_q == lmsp_pkg::LAST_BYTE)
						byte_cnt_q <= '0;
					else
						byte_cnt_q <= byte_cnt_q + 1'b1;
					loaded_q <= (byte_cnt_q == lmsp_pkg::LAST_BYTE);
				end
				default: ;
			endcase
		end
	end

	// hold the result until the consumer takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == lmsp_pkg::S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lmsp_pkg::S_FIN && out_free) begin
			out_ch_q     <= ch_drive_q;
			out_col_q    <= col_drive_q;
			out_loaded_q <= loaded_q;
		end
	end

	// capture the level byte; kind is decoded at accept
	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_q <= data_byte;
		end
	end

endmodule

// ===== sv/lmsp_checker.sv =====
// ----------------------------------------------------------------------------
// lmsp_checker: port-level checks of the LED matrix scan/PWM loader
// Result hold, column select shape, busy period after an accepted item and no frame commit for a tick.
// ----------------------------------------------------------------------------
module lmsp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            kind,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [lmsp_pkg::DRIVE_W-1:0]    channel_drive,
	input logic [lmsp_pkg::DRIVE_W-1:0]    column_drive,
	input logic                            frame_loaded
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(channel_drive)
			&& $stable(column_drive) && $stable(frame_loaded))
		else $error("result changed while stalled");

	// at most one column is selected
	a_col_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(column_drive))
		else $error("column select not one-hot");

	// an accepted item keeps the block busy for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after an accepted item");

	// a tick never produces a frame commit
	a_tick_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !kind |=> ##2 !(out_valid && frame_loaded && $rose(out_valid)))
		else $error("frame commit reported for a tick");

endmodule

bind led_matrix_scan_pwm_loader_core lmsp_checker u_lmsp_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for led_matrix_scan_pwm_loader_core
// Feeds timer ticks and level-byte frames under several timing and threshold
// settings, predicts every drive/commit result in a local scan model and
// compares each result transaction against it in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int COLS  = 9;
	localparam int CHANS = 9;

	// input kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_BYTE = 1'b1;

	// register index with no register behind it
	localparam logic [lmsp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// settle time after the last result before touching registers or ending
	localparam int SETTLE_CYCLES = 2 * CHANS + 8;

	typedef struct packed {
		logic                         kind;
		logic [lmsp_pkg::LEVEL_W-1:0] level;
	} matrix_item_t;

	typedef struct packed {
		logic [lmsp_pkg::DRIVE_W-1:0] chans;
		logic [lmsp_pkg::DRIVE_W-1:0] cols;
		logic                         loaded;
	} scan_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic                            kind = KIND_TICK;
	logic [lmsp_pkg::LEVEL_W-1:0]    data_byte = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [lmsp_pkg::DRIVE_W-1:0]    channel_drive;
	logic [lmsp_pkg::DRIVE_W-1:0]    column_drive;
	logic                            frame_loaded;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [lmsp_pkg::CFG_IDX_W-1:0]  cfg_index = lmsp_pkg::CFG_MAX_LEVEL;
	logic [lmsp_pkg::TIME_W-1:0]     cfg_data = '0;

	led_matrix_scan_pwm_loader_core #(
		.COLUMNS (COLS),
		.CHANNELS(CHANS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.channel_drive(channel_drive),
		.column_drive (column_drive),
		.frame_loaded (frame_loaded),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Scan model: mirror of the block's registers and stores
	// ------------------------------------------------------------------
	logic [lmsp_pkg::LEVEL_W-1:0] shown_levels [CHANS][COLS];
	logic [lmsp_pkg::LEVEL_W-1:0] staged_levels [CHANS][COLS];
	int                           scan_col;
	logic [lmsp_pkg::LEVEL_W-1:0] pwm_thresh;
	logic                         on_next;
	logic [lmsp_pkg::TIME_W-1:0]  ticks_left;
	logic [lmsp_pkg::IDX_W-1:0]   bytes_seen;
	logic [lmsp_pkg::DRIVE_W-1:0] latch_chans;
	logic [lmsp_pkg::DRIVE_W-1:0] latch_cols;
	logic [lmsp_pkg::LEVEL_W-1:0] wrap_level;
	logic [lmsp_pkg::TIME_W-1:0]  on_ticks;
	logic [lmsp_pkg::TIME_W-1:0]  off_ticks;

	matrix_item_t pending_items [$];
	scan_result_t expected_scan [$];
	int           mismatches = 0;

	// Advance the scan model by one transaction and return what the block shows.
	function automatic scan_result_t scan_step(input logic is_byte,
			input logic [lmsp_pkg::LEVEL_W-1:0] lvl);
		scan_result_t                 r;
		logic [lmsp_pkg::LEVEL_W-1:0] t;
		int                           n;
		r.loaded = 1'b0;
		if (is_byte == KIND_TICK) begin
			if (ticks_left != '0) begin
				ticks_left = ticks_left - 1'b1;
			end else if (on_next) begin
				latch_chans = '0;
				for (int c = 0; c < CHANS; c++) begin
					if (shown_levels[c][scan_col] >= pwm_thresh)
						latch_chans[c] = 1'b1;
				end
				latch_cols = '0;
				latch_cols[scan_col] = 1'b1;
				ticks_left = on_ticks;
				on_next = 1'b0;
			end else begin
				latch_chans = '0;
				latch_cols = '0;
				scan_col = (scan_col + 1) % COLS;
				t = pwm_thresh + lmsp_pkg::LEVEL_STEP;
				if (t > wrap_level)
					t = t - wrap_level;
				pwm_thresh = t;
				ticks_left = off_ticks;
				on_next = 1'b1;
			end
		end else begin
			n = bytes_seen;
			if (n == 0) begin
				for (int c = 0; c < CHANS; c++)
					for (int k = 0; k < COLS; k++)
						staged_levels[c][k] = '0;
			end
			staged_levels[n % lmsp_pkg::LOAD_GROUP][n / lmsp_pkg::LOAD_GROUP] = lvl;
			if (bytes_seen == lmsp_pkg::LAST_BYTE) begin
				shown_levels = staged_levels;
				bytes_seen = '0;
				r.loaded = 1'b1;
			end else begin
				bytes_seen = bytes_seen + 1'b1;
			end
		end
		r.chans = latch_chans;
		r.cols  = latch_cols;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: sample every handshake at the rising edge
	// ------------------------------------------------------------------
	logic         in_took = 1'b0;
	scan_result_t got, want;

	always @(posedge clk) begin
		if (arst_n) begin
			in_took = in_valid && in_ready;
			// track register writes so the model uses the same settings
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lmsp_pkg::CFG_MAX_LEVEL: wrap_level = cfg_data[lmsp_pkg::LEVEL_W-1:0];
					lmsp_pkg::CFG_ON_TIME:   on_ticks = cfg_data;
					lmsp_pkg::CFG_OFF_TIME:  off_ticks = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_scan.push_back(scan_step(kind, data_byte));
			if (out_valid && out_ready) begin
				got = '{chans: channel_drive, cols: column_drive, loaded: frame_loaded};
				if (expected_scan.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result ch=%h col=%h loaded=%b",
							$realtime, got.chans, got.cols, got.loaded);
				end else begin
					want = expected_scan.pop_front();
					if (got.chans !== want.chans || got.cols !== want.cols ||
							got.loaded !== want.loaded) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch exp ch=%h col=%h loaded=%b, got ch=%h col=%h loaded=%b",
								$realtime, want.chans, want.cols, want.loaded,
								got.chans, got.cols, got.loaded);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver: present queued items in bursts separated by random gaps
	// ------------------------------------------------------------------
	int           burst_left = 1;
	int           gap_left = 0;
	matrix_item_t next_item;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				next_item = pending_items.pop_front();
				in_valid  <= 1'b1;
				kind      <= next_item.kind;
				data_byte <= next_item.level;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					// start a new burst; one in four goes back to back
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: switch between always-ready, coin-flip and heavy stalling
	// ------------------------------------------------------------------
	int stall_mode = 0;
	int stall_span = 0;

	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_span = $urandom_range(16, 128);
		end else begin
			stall_span--;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) != 0);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencing helpers
	// ------------------------------------------------------------------
	// Hold until nothing is queued, in flight or owed, then let the block settle.
	task automatic wait_quiet();
		while (pending_items.size() != 0 || in_valid || expected_scan.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lmsp_pkg::CFG_IDX_W-1:0] idx,
			input logic [lmsp_pkg::TIME_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_scan(input logic [lmsp_pkg::LEVEL_W-1:0] lvl_wrap,
			input logic [lmsp_pkg::TIME_W-1:0] t_on,
			input logic [lmsp_pkg::TIME_W-1:0] t_off);
		wait_quiet();
		write_reg(lmsp_pkg::CFG_MAX_LEVEL,
			{{(lmsp_pkg::TIME_W-lmsp_pkg::LEVEL_W){1'b0}}, lvl_wrap});
		write_reg(lmsp_pkg::CFG_ON_TIME, t_on);
		write_reg(lmsp_pkg::CFG_OFF_TIME, t_off);
	endtask

	task automatic add_item(input logic k, input logic [lmsp_pkg::LEVEL_W-1:0] lvl);
		pending_items.push_back('{kind: k, level: lvl});
	endtask

	function automatic logic [lmsp_pkg::LEVEL_W-1:0] rand_level();
		case ($urandom_range(0, 3))
			0: return lmsp_pkg::LEVEL_W'($urandom_range(0, 255));
			1: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
			default: return lmsp_pkg::LEVEL_W'($urandom_range(0, 64));
		endcase
	endfunction

	// Mostly ticks and whole nine-byte frames; a few stray bytes shift the
	// frame alignment.
	task automatic add_random(input int count, input int frame_pct);
		int made;
		int roll;
		made = 0;
		while (made < count) begin
			roll = $urandom_range(0, 99);
			if (roll < frame_pct) begin
				for (int b = 0; b < lmsp_pkg::LOAD_BYTES; b++)
					add_item(KIND_BYTE, rand_level());
				made += lmsp_pkg::LOAD_BYTES;
			end else if (roll < frame_pct + 4) begin
				add_item(KIND_BYTE, rand_level());
				made++;
			end else begin
				add_item(KIND_TICK, lmsp_pkg::LEVEL_W'($urandom_range(0, 255)));
				made++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		// model state after reset
		for (int c = 0; c < CHANS; c++)
			for (int k = 0; k < COLS; k++) begin
				shown_levels[c][k]  = '0;
				staged_levels[c][k] = '0;
			end
		scan_col    = 0;
		pwm_thresh  = lmsp_pkg::THRESH_RST;
		on_next     = 1'b1;
		ticks_left  = '0;
		bytes_seen  = '0;
		latch_chans = '0;
		latch_cols  = '0;
		wrap_level  = lmsp_pkg::MAX_LEVEL_RST;
		on_ticks    = lmsp_pkg::ON_TIME_RST;
		off_ticks   = lmsp_pkg::OFF_TIME_RST;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset settings: first tick fires the on phase at once,
		// then a full frame with extreme levels, then running countdown ticks.
		add_item(KIND_TICK, 8'h00);
		add_item(KIND_BYTE, 8'hFF);
		add_item(KIND_BYTE, 8'h00);
		add_item(KIND_BYTE, 8'h01);
		add_item(KIND_BYTE, 8'd50);
		add_item(KIND_BYTE, 8'd49);
		add_item(KIND_BYTE, 8'h80);
		add_item(KIND_BYTE, 8'h02);
		add_item(KIND_BYTE, 8'h03);
		add_item(KIND_BYTE, 8'hFE);
		add_item(KIND_TICK, 8'hFF);
		add_item(KIND_TICK, 8'h00);

		// Directed, every tick fires: walk on/off phases with a wrap level of 1.
		set_scan(8'd1, 16'd0, 16'd0);
		for (int i = 0; i < 14; i++)
			add_item(KIND_TICK, 8'h00);

		// Random phases across timing and wrap extremes; each one drains
		// completely before the next register update.
		set_scan(8'd50, 16'd3, 16'd2);
		add_random(200, 30);
		set_scan(8'd252, 16'd0, 16'd0);
		add_random(200, 25);
		set_scan(8'd1, 16'd1, 16'd0);
		add_random(150, 25);
		// zero wrap: threshold wraps mod 256 and eventually lands on zero
		set_scan(8'd0, 16'd0, 16'd0);
		add_random(300, 8);
		set_scan(8'd255, 16'd0, 16'd1);
		add_random(200, 25);
		set_scan(8'd128, 16'hFFFF, 16'hFFFF);
		add_random(60, 30);
		set_scan(8'd20, 16'd2, 16'd1);
		write_reg(CFG_SPARE, lmsp_pkg::TIME_W'($urandom_range(0, 65535)));
		add_random(200, 30);
		set_scan(8'd252, 16'd0, 16'd3);
		add_random(200, 20);
		set_scan(8'd7, 16'd0, 16'd0);
		add_random(200, 40);
		set_scan(8'd200, 16'd5, 16'd0);
		add_random(200, 30);
		set_scan(lmsp_pkg::MAX_LEVEL_RST, lmsp_pkg::ON_TIME_RST, lmsp_pkg::OFF_TIME_RST);
		add_random(50, 30);

		wait_quiet();
		if (expected_scan.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("PASS led_matrix_scan_pwm_loader_core");
		else
			$display("FAIL led_matrix_scan_pwm_loader_core");
		$finish;
	end

	// Drop the run if handshakes stop making progress.
	initial begin
		#20_000_000;
		$display("FAIL led_matrix_scan_pwm_loader_core");
		$finish;
	end

endmodule
